// File: sv/acd_pkg.sv
// Shared types and constants for the three-digit auto-ranging display scan.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package acd_pkg;

  localparam int VALUE_BITS_DEF    = 20;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int NUM_DIGITS   = 3;
  localparam int DIGIT_W      = 4;
  localparam int POS_W        = 2;
  localparam int POINT_W      = NUM_DIGITS - 1;
  localparam int SPLIT_STAGES = 4;
  localparam int PIPE_STAGES  = SPLIT_STAGES + 2;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int S_USER_W    = 4;
  localparam int M_DATA_W    = 8;
  localparam int M_USER_W    = 1;

  localparam logic [CFG_DATA_W-1:0] REFRESH_RESET = 8'd100;
  localparam logic [CFG_DATA_W-1:0] BLANK_RESET   = 8'd50;
  localparam logic [DIGIT_W-1:0]    BLANK_CODE    = 4'd10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_REFRESH_TICKS = 1'b0,
    CFG_BLANK_AFTER   = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_TEMPERATURE = 2'd0,
    MODE_ANGLE       = 2'd1
  } mode_e;

  typedef enum logic [1:0] {
    CHOICE_HOLD  = 2'd0,
    CHOICE_PITCH = 2'd1,
    CHOICE_ROLL  = 2'd2
  } choice_e;

  typedef struct packed {
    mode_e   mode;
    choice_e choice;
    logic    alarm;
  } side_t;

  // digits[0] is the hundreds digit; points[i] lights the point after digit i
  typedef struct packed {
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
    logic [POINT_W-1:0]                 points;
  } split_t;

  typedef struct packed {
    logic               drive_valid;
    logic [POS_W-1:0]   position;
    logic [DIGIT_W-1:0] code;
    logic               point;
  } drive_t;

  // split of a zero value: two decimals, point after the first digit
  localparam split_t HELD_RESET = '{digits: '0, points: 2'b01};

endpackage

// File: sv/acd_flow.sv
// Valid tracking and stage load enables for the transfer pipeline.
// Depends on acd_pkg.
`timescale 1ns / 1ps

module acd_flow (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [acd_pkg::PIPE_STAGES-1:0]  load_o
);

  logic [acd_pkg::PIPE_STAGES-1:0] valid_q;
  logic [acd_pkg::PIPE_STAGES-1:0] valid_d;
  logic [acd_pkg::PIPE_STAGES-1:0] room;

  always_comb begin
    room[acd_pkg::PIPE_STAGES-1] = !valid_q[acd_pkg::PIPE_STAGES-1] || out_ready_i;
    for (int k = acd_pkg::PIPE_STAGES - 2; k >= 0; k--) begin
      room[k] = !valid_q[k] || room[k+1];
    end
    load_o[0]  = in_valid_i && room[0];
    valid_d[0] = room[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < acd_pkg::PIPE_STAGES; k++) begin
      load_o[k]  = valid_q[k-1] && room[k];
      valid_d[k] = room[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = room[0];
  assign out_valid_o = valid_q[acd_pkg::PIPE_STAGES-1];

endmodule

// File: sv/acd_split.sv
// Four-stage auto-ranging and decimal split of one fixed-point value.
// Depends on acd_pkg.
`timescale 1ns / 1ps

module acd_split #(
  parameter int VALUE_BITS    = acd_pkg::VALUE_BITS_DEF,
  parameter int FRACTION_BITS = acd_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic [acd_pkg::SPLIT_STAGES-1:0]  en_i,
  input  logic signed [VALUE_BITS-1:0]      value_i,
  output acd_pkg::split_t                   split_o
);

  localparam int MagW     = VALUE_BITS - 1;
  localparam int WideBase = (MagW > FRACTION_BITS + 7) ? MagW : FRACTION_BITS + 7;
  localparam int ProdW    = WideBase + 7;
  localparam int DispRaw  = MagW - FRACTION_BITS;
  localparam int DispW    = (DispRaw > 10) ? DispRaw : 10;
  localparam int ShiftW   = DispW + 10;
  localparam int RecipW   = DispW + 1;
  localparam int QuotW    = DispW - 9;
  localparam int MulW     = DispW + RecipW;

  localparam logic [ProdW-1:0]  TenFx     = ProdW'(64'd10 << FRACTION_BITS);
  localparam logic [ProdW-1:0]  HundredFx = ProdW'(64'd100 << FRACTION_BITS);
  localparam logic [RecipW-1:0] Recip     = RecipW'((64'd1 << ShiftW) / 64'd1000);

  // stage 1: clamp, range, scale
  logic [MagW-1:0]                    mag;
  logic [ProdW-1:0]                   mag_w;
  logic [ProdW-1:0]                   scaled;
  logic [acd_pkg::POINT_W-1:0]        pts1_d;
  logic [DispW-1:0]                   disp1_q;
  logic [acd_pkg::POINT_W-1:0]        pts1_q;
  // stage 2: quotient by 1000
  logic [MulW-1:0]                    prod;
  logic [QuotW-1:0]                   quot2_q;
  logic [DispW-1:0]                   disp2_q;
  logic [acd_pkg::POINT_W-1:0]        pts2_q;
  // stage 3: remainder by 1000
  logic [DispW:0]                     rem_w;
  logic [10:0]                        rem11;
  logic [9:0]                         rem_d;
  logic [9:0]                         rem3_q;
  logic [acd_pkg::POINT_W-1:0]        pts3_q;
  // stage 4: three digits
  logic [15:0]                        hund_prod;
  logic [17:0]                        tens_prod;
  logic [acd_pkg::DIGIT_W-1:0]        hund;
  logic [6:0]                         tens_all;
  acd_pkg::split_t                    split_d;
  acd_pkg::split_t                    split_q;

  always_comb begin
    mag   = value_i[VALUE_BITS-1] ? '0 : value_i[MagW-1:0];
    mag_w = ProdW'(mag);
    if (mag_w < TenFx) begin
      scaled = mag_w * ProdW'(100);
      pts1_d = 2'b01;
    end else if (mag_w < HundredFx) begin
      scaled = mag_w * ProdW'(10);
      pts1_d = 2'b10;
    end else begin
      scaled = mag_w;
      pts1_d = 2'b00;
    end
  end

  assign prod = MulW'(disp1_q) * MulW'(Recip);

  always_comb begin
    rem_w = (DispW + 1)'(disp2_q) - (DispW + 1)'(quot2_q) * (DispW + 1)'(1000);
    rem11 = rem_w[10:0];
    rem_d = (rem11 >= 11'd1000) ? 10'(rem11 - 11'd1000) : rem11[9:0];
  end

  always_comb begin
    hund_prod              = 16'(rem3_q) * 16'd41;
    tens_prod              = 18'(rem3_q) * 18'd205;
    hund                   = hund_prod[15:12];
    tens_all               = tens_prod[17:11];
    split_d.digits[0]      = hund;
    split_d.digits[1]      = 4'(tens_all - 7'(hund) * 7'd10);
    split_d.digits[2]      = 4'(rem3_q - 10'(tens_all) * 10'd10);
    split_d.points         = pts3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      disp1_q <= DispW'(scaled >> FRACTION_BITS);
      pts1_q  <= pts1_d;
    end
    if (en_i[1]) begin
      quot2_q <= QuotW'(prod >> ShiftW);
      disp2_q <= disp1_q;
      pts2_q  <= pts1_q;
    end
    if (en_i[2]) begin
      rem3_q <= rem_d;
      pts3_q <= pts2_q;
    end
    if (en_i[3]) begin
      split_q <= split_d;
    end
  end

  assign split_o = split_q;

endmodule

// File: sv/acd_scan.sv
// Scan state, refresh counter, held angle, blanking and the result register.
// Depends on acd_pkg.
`timescale 1ns / 1ps

module acd_scan (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  acd_pkg::side_t                     side_i,
  input  acd_pkg::split_t                    temp_split_i,
  input  acd_pkg::split_t                    angle_split_i,
  input  logic [acd_pkg::CFG_DATA_W-1:0]     refresh_ticks_i,
  input  logic [acd_pkg::CFG_DATA_W-1:0]     blank_after_i,
  output acd_pkg::drive_t                    drive_o
);

  localparam logic [acd_pkg::POS_W-1:0] LastPos = acd_pkg::POS_W'(acd_pkg::NUM_DIGITS - 1);

  logic [7:0]                  tick_q;
  logic [7:0]                  tick_d;
  logic [7:0]                  tick_inc;
  logic [acd_pkg::POS_W-1:0]   scan_q;
  logic [acd_pkg::POS_W-1:0]   scan_d;
  acd_pkg::split_t             held_q;
  acd_pkg::split_t             held_d;
  acd_pkg::split_t             shown_q;
  acd_pkg::split_t             shown_d;
  acd_pkg::split_t             src;
  acd_pkg::drive_t             drive_q;
  acd_pkg::drive_t             drive_d;
  logic                        drive_on;
  logic                        latch;

  always_comb begin
    tick_inc = (tick_q == 8'hFF) ? tick_q : tick_q + 8'd1;
    scan_d   = (scan_q == LastPos) ? '0 : scan_q + acd_pkg::POS_W'(1);

    case (side_i.choice)
      acd_pkg::CHOICE_PITCH, acd_pkg::CHOICE_ROLL: begin
        held_d = angle_split_i;
      end
      default: begin
        held_d = held_q;
      end
    endcase

    drive_on = (side_i.mode == acd_pkg::MODE_TEMPERATURE) ||
               (side_i.mode == acd_pkg::MODE_ANGLE);
    latch    = drive_on && (tick_inc > refresh_ticks_i);
    src      = (side_i.mode == acd_pkg::MODE_TEMPERATURE) ? temp_split_i : held_d;
    shown_d  = latch ? src : shown_q;
    tick_d   = latch ? '0 : tick_inc;

    // blank under alarm once past the blank point
    if (drive_on && side_i.alarm && (tick_d > blank_after_i)) begin
      shown_d.digits = {acd_pkg::NUM_DIGITS{acd_pkg::BLANK_CODE}};
    end

    drive_d             = '0;
    drive_d.drive_valid = drive_on;
    if (drive_on) begin
      drive_d.position = scan_d;
      case (scan_d)
        2'd0: begin
          drive_d.code  = shown_d.digits[0];
          drive_d.point = shown_d.points[0];
        end
        2'd1: begin
          drive_d.code  = shown_d.digits[1];
          drive_d.point = shown_d.points[1];
        end
        default: begin
          drive_d.code  = shown_d.digits[2];
          drive_d.point = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      scan_q  <= '0;
      held_q  <= acd_pkg::HELD_RESET;
      shown_q <= '0;
      drive_q <= '0;
    end else if (load_i) begin
      tick_q  <= tick_d;
      scan_q  <= scan_d;
      held_q  <= held_d;
      shown_q <= shown_d;
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

// File: sv/autorange_three_digit_display_scan.sv
// Three-digit auto-ranging display scan: one digit drive per scan tick.
// Throughput: one item per cycle while the output is not stalled; input register, four split stages, result register.
// Reset: pipeline empty, counter and scan at zero, held angle reads as zero,
// shown digits zero with no point, refresh_ticks 100, blank_after 50.
`timescale 1ns / 1ps

module autorange_three_digit_display_scan #(
  parameter int VALUE_BITS    = acd_pkg::VALUE_BITS_DEF,
  parameter int FRACTION_BITS = acd_pkg::FRACTION_BITS_DEF,
  parameter int S_DATA_W      = ((3 * VALUE_BITS + 1 + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // temperature_value, pitch_value, roll_value, alarm_on, zero fill
  input  logic [S_DATA_W-1:0]                s_axis_tdata,
  // display_mode, angle_choice
  input  logic [acd_pkg::S_USER_W-1:0]       s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // digit_position, digit_code, point_on, zero fill
  output logic [acd_pkg::M_DATA_W-1:0]       m_axis_tdata,
  // drive_valid
  output logic [acd_pkg::M_USER_W-1:0]       m_axis_tuser,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [acd_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [acd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [acd_pkg::PIPE_STAGES-1:0]  load;
  logic [acd_pkg::CFG_DATA_W-1:0]   refresh_q;
  logic [acd_pkg::CFG_DATA_W-1:0]   blank_q;
  logic signed [VALUE_BITS-1:0]     temp_q;
  logic signed [VALUE_BITS-1:0]     pitch_q;
  logic signed [VALUE_BITS-1:0]     roll_q;
  logic signed [VALUE_BITS-1:0]     angle_pick;
  acd_pkg::side_t                   side_in;
  acd_pkg::side_t                   side_q [acd_pkg::SPLIT_STAGES+1];
  acd_pkg::split_t                  temp_split;
  acd_pkg::split_t                  angle_split;
  acd_pkg::drive_t                  drive;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_q <= acd_pkg::REFRESH_RESET;
      blank_q   <= acd_pkg::BLANK_RESET;
    end else if (cfg_valid_i) begin
      case (acd_pkg::cfg_reg_e'(cfg_index_i))
        acd_pkg::CFG_REFRESH_TICKS: refresh_q <= cfg_data_i;
        acd_pkg::CFG_BLANK_AFTER:   blank_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  acd_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .load_o      (load)
  );

  assign side_in.mode   = acd_pkg::mode_e'(s_axis_tuser[1:0]);
  assign side_in.choice = acd_pkg::choice_e'(s_axis_tuser[3:2]);
  assign side_in.alarm  = s_axis_tdata[3*VALUE_BITS];

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      temp_q    <= s_axis_tdata[VALUE_BITS-1:0];
      pitch_q   <= s_axis_tdata[2*VALUE_BITS-1:VALUE_BITS];
      roll_q    <= s_axis_tdata[3*VALUE_BITS-1:2*VALUE_BITS];
      side_q[0] <= side_in;
    end
    for (int k = 1; k <= acd_pkg::SPLIT_STAGES; k++) begin
      if (load[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign angle_pick = (side_q[0].choice == acd_pkg::CHOICE_PITCH) ? pitch_q : roll_q;

  acd_split #(
    .VALUE_BITS    (VALUE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_split_temp (
    .clk_i   (clk_i),
    .en_i    (load[acd_pkg::SPLIT_STAGES:1]),
    .value_i (temp_q),
    .split_o (temp_split)
  );

  acd_split #(
    .VALUE_BITS    (VALUE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_split_angle (
    .clk_i   (clk_i),
    .en_i    (load[acd_pkg::SPLIT_STAGES:1]),
    .value_i (angle_pick),
    .split_o (angle_split)
  );

  acd_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load[acd_pkg::PIPE_STAGES-1]),
    .side_i          (side_q[acd_pkg::SPLIT_STAGES]),
    .temp_split_i    (temp_split),
    .angle_split_i   (angle_split),
    .refresh_ticks_i (refresh_q),
    .blank_after_i   (blank_q),
    .drive_o         (drive)
  );

  assign m_axis_tdata = {1'b0, drive.point, drive.code, drive.position};
  assign m_axis_tuser = drive.drive_valid;

endmodule
